### rtl/core/quadratic_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_defines
// assertion macros used by the hash table rtl
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define QPHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qpht assertion failed");
// next-cycle implication
`define QPHT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qpht assertion failed");
`else
`define QPHT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QPHT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/core/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// types and constants of the quadratic probe hash table
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int KEY_W         = 31;
  localparam int MODE_W        = 1;
  localparam int STATUS_W      = 2;
  localparam int SLOT_W        = 10;
  localparam int SIZE_CFG_W    = 11;
  localparam int WORD_W        = KEY_W + 1;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } slot_cmd_t;

endpackage

### rtl/core/qpht_if.sv
// ----------------------------------------------------------------------------
// qpht_if
// request and response channels of the hash table
// ----------------------------------------------------------------------------
interface qpht_req_if;
  logic                           valid;
  logic                           ready;
  logic [qpht_pkg::MODE_W-1:0]    mode;
  logic [qpht_pkg::KEY_W-1:0]     key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface qpht_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [qpht_pkg::STATUS_W-1:0]  status;
  logic [qpht_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

### rtl/core/qpht_mod_unit.sv
// ----------------------------------------------------------------------------
// qpht_mod_unit
// restoring remainder unit, one key bit per cycle
// ----------------------------------------------------------------------------
module qpht_mod_unit #(
  parameter int TABLE_DEPTH = qpht_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [qpht_pkg::KEY_W-1:0]    dividend,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] divisor,
  output logic                          done,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rem_out
);

  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(qpht_pkg::KEY_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [qpht_pkg::KEY_W-1:0] quo_sh;
  logic [SW-1:0]              div_r;
  logic [SW-1:0]              rem;
  logic [SW:0]                trial;
  logic [SW:0]                trial_sub;

  always_comb begin
    trial     = {rem, quo_sh[qpht_pkg::KEY_W-1]};
    trial_sub = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(qpht_pkg::KEY_W - 1);
        quo_sh <= dividend;
        div_r  <= divisor;
        rem    <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, div_r}) begin
          rem <= trial_sub[SW-1:0];
        end else begin
          rem <= trial[SW-1:0];
        end
        quo_sh <= {quo_sh[qpht_pkg::KEY_W-2:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rem_out = AW'(rem);

endmodule

### rtl/core/qpht_slot_store.sv
// ----------------------------------------------------------------------------
// qpht_slot_store
// single-port slot memory with a clearing pass after reset
// ----------------------------------------------------------------------------
module qpht_slot_store #(
  parameter int TABLE_DEPTH = qpht_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qpht_pkg::slot_cmd_t           cmd,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] addr,
  input  logic [qpht_pkg::WORD_W-1:0]   wr_data,
  output logic [qpht_pkg::WORD_W-1:0]   rd_data,
  output logic                          clear_busy
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [qpht_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
  logic [AW-1:0]               clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
        clear_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

### rtl/core/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// open-addressed key set with quadratic probing over a slot memory
// ----------------------------------------------------------------------------
// usage:
//   req carries mode (0 insert, 1 search) and a 31-bit key; rsp returns
//   status (inserted, full, found, not found) and the slot index.
//   cfg_wr_en/cfg_wr_data set table_size (0 acts as 1, clipped to depth).
// timing:
//   one request at a time; the home slot comes from a bit-serial remainder
//   unit, then each probe is a memory read followed by a check.
// reset:
//   table_size returns to 1024; the slot memory is cleared one entry per
//   cycle, with req.ready low until done.
// stall:
//   rsp is a register: the next request is taken while a result waits;
//   a finished result holds inside until the output register frees.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = qpht_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [qpht_pkg::SIZE_CFG_W-1:0]    cfg_wr_data,
  qpht_req_if.sink                           req,
  qpht_rsp_if.source                         rsp
);

  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = SW + 1;
  localparam int CW = (SW > qpht_pkg::SIZE_CFG_W) ? SW : qpht_pkg::SIZE_CFG_W;
  localparam int MW = (AW > qpht_pkg::SLOT_W) ? AW : qpht_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t                         state;
  logic [qpht_pkg::SIZE_CFG_W-1:0] table_size;
  logic [qpht_pkg::MODE_W-1:0]    mode_r;
  logic [qpht_pkg::KEY_W-1:0]     key_r;
  logic [SW-1:0]                  size_r;
  logic [AW-1:0]                  idx;
  logic [AW-1:0]                  step;
  logic [SW-1:0]                  cnt;
  qpht_pkg::status_t              res_status;
  logic [qpht_pkg::SLOT_W-1:0]    res_slot;
  logic                           out_valid;
  logic [qpht_pkg::STATUS_W-1:0]  out_status;
  logic [qpht_pkg::SLOT_W-1:0]    out_slot;

  logic                           req_fire;
  logic [CW-1:0]                  size_ext;
  logic [CW-1:0]                  size_clip;
  logic [SW-1:0]                  size_act;
  logic                           mod_done;
  logic [AW-1:0]                  home;
  qpht_pkg::slot_cmd_t            cmd;
  logic [qpht_pkg::WORD_W-1:0]    rd_word;
  logic                           clear_busy;
  logic                           hit;
  logic                           empty;
  logic                           last;
  logic [SW-1:0]                  cnt_inc;
  logic [EW-1:0]                  idx_sum;
  logic [AW-1:0]                  idx_next;
  logic [EW-1:0]                  step_a;
  logic [EW-1:0]                  step_b;
  logic [AW-1:0]                  step_next;
  logic [MW-1:0]                  idx_wide;

  // active size: zero acts as one, clipped to the depth
  always_comb begin
    size_ext = CW'(table_size);
    if (size_ext == '0) begin
      size_clip = CW'(1);
    end else if (size_ext > CW'(TABLE_DEPTH)) begin
      size_clip = CW'(TABLE_DEPTH);
    end else begin
      size_clip = size_ext;
    end
    size_act = size_clip[SW-1:0];
  end

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  qpht_mod_unit #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (req_fire),
    .dividend (req.key),
    .divisor  (size_act),
    .done     (mod_done),
    .rem_out  (home)
  );

  always_comb begin
    hit     = rd_word[qpht_pkg::WORD_W-1] && (rd_word[qpht_pkg::KEY_W-1:0] == key_r);
    empty   = !rd_word[qpht_pkg::WORD_W-1];
    cnt_inc = cnt + 1'b1;
    last    = (cnt_inc == size_r);
    // next probe: idx + (2i+1), step + 2, both mod size
    idx_sum = EW'(idx) + EW'(step);
    if (idx_sum >= EW'(size_r)) begin
      idx_sum = idx_sum - EW'(size_r);
    end
    idx_next = AW'(idx_sum);
    step_a = EW'(step) + EW'(2);
    if (step_a >= EW'(size_r)) begin
      step_a = step_a - EW'(size_r);
    end
    step_b = step_a;
    if (step_b >= EW'(size_r)) begin
      step_b = step_b - EW'(size_r);
    end
    step_next = AW'(step_b);
    idx_wide  = MW'(idx);
    cmd.rd_en = (state == S_READ);
    cmd.wr_en = (state == S_EVAL) && (mode_r == qpht_pkg::MODE_INSERT) && (empty || hit);
  end

  qpht_slot_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .addr       (idx),
    .wr_data    ({1'b1, key_r}),
    .rd_data    (rd_word),
    .clear_busy (clear_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      table_size <= qpht_pkg::SIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!clear_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            mode_r <= req.mode;
            key_r  <= req.key;
            size_r <= size_act;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            idx   <= home;
            step  <= (size_r == SW'(1)) ? AW'(0) : AW'(1);
            cnt   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (mode_r == qpht_pkg::MODE_SEARCH) begin
            if (hit) begin
              res_status <= qpht_pkg::ST_FOUND;
              res_slot   <= idx_wide[qpht_pkg::SLOT_W-1:0];
              state      <= S_DONE;
            end else if (empty || last) begin
              res_status <= qpht_pkg::ST_NOT_FOUND;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              idx   <= idx_next;
              step  <= step_next;
              cnt   <= cnt_inc;
              state <= S_READ;
            end
          end else begin
            if (empty || hit) begin
              res_status <= qpht_pkg::ST_INSERTED;
              res_slot   <= idx_wide[qpht_pkg::SLOT_W-1:0];
              state      <= S_DONE;
            end else if (last) begin
              res_status <= qpht_pkg::ST_FULL;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              idx   <= idx_next;
              step  <= step_next;
              cnt   <= cnt_inc;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_slot   <= res_slot;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot   = out_slot;

  `QPHT_ASSERT_NXT(a_busy_after_req, clk, rst, req_fire, !req.ready)
  `QPHT_ASSERT_IMP(a_mod_done_in_div, clk, rst, mod_done, state == S_DIV)
  `QPHT_ASSERT_IMP(a_write_on_insert, clk, rst, cmd.wr_en, mode_r == qpht_pkg::MODE_INSERT)
  `QPHT_ASSERT_IMP(a_probe_in_range, clk, rst, state == S_READ || state == S_EVAL, EW'(idx) < EW'(size_r))

endmodule
